FILE: hw/rtl/sscc_pkg.sv
// sscc_pkg: shared widths, codes, types and the per-item and per-sphere microcode
// table for the segment/sphere collision checker; no dependencies
`default_nettype none

package sscc_pkg;

    localparam int COORD_W    = 32;
    localparam int RAD_W      = 31;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_NUM    = 6;
    localparam int OPND_W     = 68;
    localparam int DIG_W      = 34;
    localparam int ACC_W      = 136;
    localparam int PC_W       = 6;

    localparam int DEF_MAX_SPHERES = 64;
    localparam int DEF_DIMENSIONS  = 3;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEG   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOB     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_Z  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_Z = 3'd5;

    // microcode entry points
    localparam logic [PC_W-1:0] PC_DD = 6'd0;
    localparam logic [PC_W-1:0] PC_T  = 6'd5;
    localparam logic [PC_W-1:0] PC_P  = 6'd9;
    localparam logic [PC_W-1:0] PC_Q  = 6'd14;
    localparam logic [PC_W-1:0] PC_X  = 6'd19;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SPHERE,
        S_LOADW,
        S_MICRO,
        S_MWAIT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_W0, OP_W1, OP_W2,
        OP_D0, OP_D1, OP_D2,
        OP_E0, OP_E1, OP_E2,
        OP_RAD, OP_DD, OP_TMP
    } opnd_t;

    typedef enum logic [3:0] {
        U_MUL,
        U_TMP,
        U_DD,
        U_SUMCLR,
        U_SUMSUB,
        U_SUMADD,
        U_BEGIN,
        U_BRANCH,
        U_TEST_ACC,
        U_TEST_SUM
    } uop_kind_t;

    typedef struct packed {
        uop_kind_t kind;
        opnd_t     a;
        opnd_t     b;
        logic      clr;
        logic      sub;
    } uop_t;

    typedef struct packed {
        logic                ld_item;
        logic                cnt_clr;
        logic                add_wr;
        logic                idx_clr;
        logic                idx_inc;
        logic                rd_en;
        logic                load_sph;
        logic                mul_start;
        opnd_t               a_sel;
        opnd_t               b_sel;
        logic                mul_clr;
        logic                mul_sub;
        logic                tmp_ld;
        logic                dd_ld;
        logic                sum_clr;
        logic                sum_add;
        logic                sum_sub;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              bounds_ok;
        logic              full;
        logic              idx_end;
        logic              mul_done;
        logic              acc_le0;
        logic              acc_ge_dd;
        logic              acc_ge0;
        logic              acc_gt0;
        logic              sum_ge0;
    } dp_stat_t;

    function automatic uop_t mk(input uop_kind_t k, input opnd_t a, input opnd_t b,
                                input logic clr, input logic sub);
        uop_t u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.clr  = clr;
        u.sub  = sub;
        return u;
    endfunction

    // dd = |d|^2, then per sphere: t = w.d, branch to endpoint p, endpoint q
    // or the cross-product test |w x d|^2 <= r^2 * dd
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            6'd0:    u = mk(U_MUL, OP_D0, OP_D0, 1'b1, 1'b0);
            6'd1:    u = mk(U_MUL, OP_D1, OP_D1, 1'b0, 1'b0);
            6'd2:    u = mk(U_MUL, OP_D2, OP_D2, 1'b0, 1'b0);
            6'd3:    u = mk(U_DD, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd4:    u = mk(U_BEGIN, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd5:    u = mk(U_MUL, OP_W0, OP_D0, 1'b1, 1'b0);
            6'd6:    u = mk(U_MUL, OP_W1, OP_D1, 1'b0, 1'b0);
            6'd7:    u = mk(U_MUL, OP_W2, OP_D2, 1'b0, 1'b0);
            6'd8:    u = mk(U_BRANCH, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd9:    u = mk(U_MUL, OP_RAD, OP_RAD, 1'b1, 1'b0);
            6'd10:   u = mk(U_MUL, OP_W0, OP_W0, 1'b0, 1'b1);
            6'd11:   u = mk(U_MUL, OP_W1, OP_W1, 1'b0, 1'b1);
            6'd12:   u = mk(U_MUL, OP_W2, OP_W2, 1'b0, 1'b1);
            6'd13:   u = mk(U_TEST_ACC, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd14:   u = mk(U_MUL, OP_RAD, OP_RAD, 1'b1, 1'b0);
            6'd15:   u = mk(U_MUL, OP_E0, OP_E0, 1'b0, 1'b1);
            6'd16:   u = mk(U_MUL, OP_E1, OP_E1, 1'b0, 1'b1);
            6'd17:   u = mk(U_MUL, OP_E2, OP_E2, 1'b0, 1'b1);
            6'd18:   u = mk(U_TEST_ACC, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd19:   u = mk(U_SUMCLR, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd20:   u = mk(U_MUL, OP_W0, OP_D1, 1'b1, 1'b0);
            6'd21:   u = mk(U_MUL, OP_W1, OP_D0, 1'b0, 1'b1);
            6'd22:   u = mk(U_TMP, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd23:   u = mk(U_MUL, OP_TMP, OP_TMP, 1'b1, 1'b0);
            6'd24:   u = mk(U_SUMSUB, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd25:   u = mk(U_MUL, OP_W0, OP_D2, 1'b1, 1'b0);
            6'd26:   u = mk(U_MUL, OP_W2, OP_D0, 1'b0, 1'b1);
            6'd27:   u = mk(U_TMP, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd28:   u = mk(U_MUL, OP_TMP, OP_TMP, 1'b1, 1'b0);
            6'd29:   u = mk(U_SUMSUB, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd30:   u = mk(U_MUL, OP_W1, OP_D2, 1'b1, 1'b0);
            6'd31:   u = mk(U_MUL, OP_W2, OP_D1, 1'b0, 1'b1);
            6'd32:   u = mk(U_TMP, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd33:   u = mk(U_MUL, OP_TMP, OP_TMP, 1'b1, 1'b0);
            6'd34:   u = mk(U_SUMSUB, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd35:   u = mk(U_MUL, OP_RAD, OP_RAD, 1'b1, 1'b0);
            6'd36:   u = mk(U_TMP, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd37:   u = mk(U_MUL, OP_TMP, OP_DD, 1'b1, 1'b0);
            6'd38:   u = mk(U_SUMADD, OP_D0, OP_D0, 1'b0, 1'b0);
            6'd39:   u = mk(U_TEST_SUM, OP_D0, OP_D0, 1'b0, 1'b0);
            default: u = mk(U_BEGIN, OP_D0, OP_D0, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sscc_ram.sv
// sscc_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module sscc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sscc_mul.sv
// sscc_mul: 68x68 signed multiplier, magnitude form, one 34x34 partial a cycle
// depends on sscc_pkg
`default_nettype none

module sscc_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [sscc_pkg::OPND_W-1:0] a,
    input  logic signed [sscc_pkg::OPND_W-1:0] b,
    output logic                               done,
    output logic                               neg,
    output logic [sscc_pkg::ACC_W-1:0]         mag
);

    import sscc_pkg::*;

    logic [OPND_W-1:0]  am_reg;
    logic [OPND_W-1:0]  bm_reg;
    logic               neg_reg;
    logic [2:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [2*DIG_W-1:0] part_reg;
    logic [1:0]         psum_reg;
    logic [ACC_W-1:0]   mag_reg;
    logic [DIG_W-1:0]   a_dig;
    logic [DIG_W-1:0]   b_dig;
    logic [ACC_W-1:0]   part_sh;

    assign a_dig = cnt_reg[1] ? am_reg[OPND_W-1:DIG_W] : am_reg[DIG_W-1:0];
    assign b_dig = cnt_reg[0] ? bm_reg[OPND_W-1:DIG_W] : bm_reg[DIG_W-1:0];

    always_comb
    begin
        case (psum_reg)
            2'd0:    part_sh = ACC_W'(part_reg);
            2'd1:    part_sh = ACC_W'(part_reg) << DIG_W;
            default: part_sh = ACC_W'(part_reg) << (2 * DIG_W);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            am_reg  <= a[OPND_W-1] ? OPND_W'(-a) : OPND_W'(a);
            bm_reg  <= b[OPND_W-1] ? OPND_W'(-b) : OPND_W'(b);
            neg_reg <= a[OPND_W-1] ^ b[OPND_W-1];
            mag_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                part_reg <= a_dig * b_dig;
                psum_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0)
            begin
                mag_reg <= mag_reg + part_sh;
            end
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign mag  = mag_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sscc_datapath.sv
// sscc_datapath: bounds registers, item and sphere registers, sphere tables,
// shared multiplier, accumulators and result register; depends on sscc_pkg,
// sscc_ram and sscc_mul
`default_nettype none

module sscc_datapath #(
    parameter int MAX_SPHERES = sscc_pkg::DEF_MAX_SPHERES,
    parameter int DIMENSIONS  = sscc_pkg::DEF_DIMENSIONS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [sscc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sscc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [sscc_pkg::MODE_W-1:0]           mode,
    input  logic signed [sscc_pkg::COORD_W-1:0]   first_x,
    input  logic signed [sscc_pkg::COORD_W-1:0]   first_y,
    input  logic signed [sscc_pkg::COORD_W-1:0]   first_z,
    input  logic signed [sscc_pkg::COORD_W-1:0]   second_x,
    input  logic signed [sscc_pkg::COORD_W-1:0]   second_y,
    input  logic signed [sscc_pkg::COORD_W-1:0]   second_z,
    input  logic [sscc_pkg::RAD_W-1:0]            sphere_radius,
    input  sscc_pkg::dp_cmd_t                     cmd,
    output sscc_pkg::dp_stat_t                    stat,
    output logic [sscc_pkg::STATUS_W-1:0]         status,
    output logic [sscc_pkg::COUNT_W-1:0]          sphere_count
);

    import sscc_pkg::*;

    localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW = $clog2(MAX_SPHERES + 1);

    logic signed [COORD_W-1:0]  bound_reg [CFG_NUM];
    logic [MODE_W-1:0]          mode_reg;
    logic signed [COORD_W-1:0]  p_reg [3];
    logic signed [COORD_W-1:0]  q_reg [3];
    logic [RAD_W-1:0]           rad_in_reg;
    logic signed [COORD_W:0]    d_val [3];
    logic signed [COORD_W:0]    w_reg [3];
    logic signed [COORD_W:0]    e_reg [3];
    logic [RAD_W-1:0]           rad_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              idx_reg;
    logic signed [COORD_W-1:0]  ctr_q [3];
    logic [RAD_W-1:0]           rad_q;
    logic signed [OPND_W-1:0]   tmp_reg;
    logic signed [OPND_W-1:0]   dd_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic                       mclr_reg;
    logic                       msub_reg;
    logic signed [OPND_W-1:0]   opa;
    logic signed [OPND_W-1:0]   opb;
    logic                       mul_done;
    logic                       mul_neg;
    logic [ACC_W-1:0]           mul_mag;
    logic signed [ACC_W-1:0]    acc_base;
    logic [2:0]                 axis_p_ok;
    logic [2:0]                 axis_q_ok;
    logic [STATUS_W-1:0]        status_reg;
    logic [COUNT_W-1:0]         count_out_reg;
    logic [CW+COUNT_W-1:0]      count_ext;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CFG_NUM; k++)
            begin
                bound_reg[k] <= (k % 2 == 0) ? {1'b1, {(COORD_W-1){1'b0}}}
                                             : {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
        else if (cfg_wr_en && (cfg_index <= CFG_HIGH_Z))
        begin
            bound_reg[cfg_index] <= cfg_data;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            mode_reg   <= mode;
            p_reg[0]   <= first_x;
            p_reg[1]   <= first_y;
            p_reg[2]   <= first_z;
            q_reg[0]   <= second_x;
            q_reg[1]   <= second_y;
            q_reg[2]   <= second_z;
            rad_in_reg <= sphere_radius;
        end
    end

    // bounds and segment direction; unused axes pass the bounds check and get a zero direction
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k < DIMENSIONS)
            begin
                axis_p_ok[k] = (p_reg[k] >= bound_reg[2*k]) && (p_reg[k] <= bound_reg[2*k+1]);
                axis_q_ok[k] = (q_reg[k] >= bound_reg[2*k]) && (q_reg[k] <= bound_reg[2*k+1]);
                d_val[k]     = (COORD_W+1)'(q_reg[k]) - (COORD_W+1)'(p_reg[k]);
            end
            else
            begin
                axis_p_ok[k] = 1'b1;
                axis_q_ok[k] = 1'b1;
                d_val[k]     = '0;
            end
        end
    end

    // sphere tables
    sscc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SPHERES)) u_ram_x (
        .clk(clk), .we(cmd.add_wr), .waddr(count_reg[AW-1:0]), .wdata(p_reg[0]),
        .re(cmd.rd_en), .raddr(idx_reg[AW-1:0]), .rdata(ctr_q[0])
    );
    sscc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SPHERES)) u_ram_y (
        .clk(clk), .we(cmd.add_wr), .waddr(count_reg[AW-1:0]), .wdata(p_reg[1]),
        .re(cmd.rd_en), .raddr(idx_reg[AW-1:0]), .rdata(ctr_q[1])
    );
    sscc_ram #(.WIDTH(COORD_W), .DEPTH(MAX_SPHERES)) u_ram_z (
        .clk(clk), .we(cmd.add_wr), .waddr(count_reg[AW-1:0]), .wdata(p_reg[2]),
        .re(cmd.rd_en), .raddr(idx_reg[AW-1:0]), .rdata(ctr_q[2])
    );
    sscc_ram #(.WIDTH(RAD_W), .DEPTH(MAX_SPHERES)) u_ram_r (
        .clk(clk), .we(cmd.add_wr), .waddr(count_reg[AW-1:0]), .wdata(rad_in_reg),
        .re(cmd.rd_en), .raddr(idx_reg[AW-1:0]), .rdata(rad_q)
    );

    // count and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                count_reg <= '0;
            end
            else if (cmd.add_wr)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // w = center - p, e = center - q
    always_ff @(posedge clk)
    begin
        if (cmd.load_sph)
        begin
            rad_reg <= rad_q;
            for (int k = 0; k < 3; k++)
            begin
                if (k < DIMENSIONS)
                begin
                    w_reg[k] <= (COORD_W+1)'(ctr_q[k]) - (COORD_W+1)'(p_reg[k]);
                    e_reg[k] <= (COORD_W+1)'(ctr_q[k]) - (COORD_W+1)'(q_reg[k]);
                end
                else
                begin
                    w_reg[k] <= '0;
                    e_reg[k] <= '0;
                end
            end
        end
    end

    // operand selection
    always_comb
    begin
        case (cmd.a_sel)
            OP_W0:   opa = OPND_W'(w_reg[0]);
            OP_W1:   opa = OPND_W'(w_reg[1]);
            OP_W2:   opa = OPND_W'(w_reg[2]);
            OP_D0:   opa = OPND_W'(d_val[0]);
            OP_D1:   opa = OPND_W'(d_val[1]);
            OP_D2:   opa = OPND_W'(d_val[2]);
            OP_E0:   opa = OPND_W'(e_reg[0]);
            OP_E1:   opa = OPND_W'(e_reg[1]);
            OP_E2:   opa = OPND_W'(e_reg[2]);
            OP_RAD:  opa = OPND_W'(rad_reg);
            OP_DD:   opa = dd_reg;
            OP_TMP:  opa = tmp_reg;
            default: opa = '0;
        endcase
        case (cmd.b_sel)
            OP_W0:   opb = OPND_W'(w_reg[0]);
            OP_W1:   opb = OPND_W'(w_reg[1]);
            OP_W2:   opb = OPND_W'(w_reg[2]);
            OP_D0:   opb = OPND_W'(d_val[0]);
            OP_D1:   opb = OPND_W'(d_val[1]);
            OP_D2:   opb = OPND_W'(d_val[2]);
            OP_E0:   opb = OPND_W'(e_reg[0]);
            OP_E1:   opb = OPND_W'(e_reg[1]);
            OP_E2:   opb = OPND_W'(e_reg[2]);
            OP_RAD:  opb = OPND_W'(rad_reg);
            OP_DD:   opb = dd_reg;
            OP_TMP:  opb = tmp_reg;
            default: opb = '0;
        endcase
    end

    sscc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .neg   (mul_neg),
        .mag   (mul_mag)
    );

    assign acc_base = mclr_reg ? '0 : acc_reg;

    // accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mclr_reg <= cmd.mul_clr;
            msub_reg <= cmd.mul_sub;
        end
        if (mul_done)
        begin
            if (msub_reg ^ mul_neg)
            begin
                acc_reg <= acc_base - $signed(mul_mag);
            end
            else
            begin
                acc_reg <= acc_base + $signed(mul_mag);
            end
        end
        if (cmd.tmp_ld)
        begin
            tmp_reg <= acc_reg[OPND_W-1:0];
        end
        if (cmd.dd_ld)
        begin
            dd_reg <= acc_reg[OPND_W-1:0];
        end
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + acc_reg;
        end
        else if (cmd.sum_sub)
        begin
            sum_reg <= sum_reg - acc_reg;
        end
    end

    // result register
    assign count_ext = {COUNT_W'(0), count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= cmd.out_status;
            count_out_reg <= count_ext[COUNT_W-1:0];
        end
    end

    assign status       = status_reg;
    assign sphere_count = count_out_reg;

    always_comb
    begin
        stat.mode      = mode_reg;
        stat.bounds_ok = (&axis_p_ok) && ((mode_reg != MODE_SEG) || (&axis_q_ok));
        stat.full      = count_reg >= CW'(MAX_SPHERES);
        stat.idx_end   = idx_reg == count_reg;
        stat.mul_done  = mul_done;
        stat.acc_le0   = acc_reg[ACC_W-1] || (acc_reg == '0);
        stat.acc_ge_dd = acc_reg >= ACC_W'(dd_reg);
        stat.acc_ge0   = !acc_reg[ACC_W-1];
        stat.acc_gt0   = !acc_reg[ACC_W-1] && (acc_reg != '0);
        stat.sum_ge0   = !sum_reg[ACC_W-1];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sscc_ctrl.sv
// sscc_ctrl: item sequencer and per-sphere microcode stepper
// depends on sscc_pkg
`default_nettype none

module sscc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  sscc_pkg::dp_stat_t stat,
    output sscc_pkg::dp_cmd_t  cmd
);

    import sscc_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [PC_W-1:0]     pc_reg;
    logic [PC_W-1:0]     pc_next;
    logic [STATUS_W-1:0] res_reg;
    logic [STATUS_W-1:0] res_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    uop_t                uo;
    logic                hit;

    assign uo = ucode(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            res_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.a_sel      = uo.a;
        cmd.b_sel      = uo.b;
        cmd.mul_clr    = uo.clr;
        cmd.mul_sub    = uo.sub;
        cmd.out_status = res_reg;
        hit            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        res_next    = ST_OK;
                        state_next  = S_FINISH;
                    end
                    MODE_ADD:
                    begin
                        if (stat.full)
                        begin
                            res_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.add_wr = 1'b1;
                            res_next   = ST_OK;
                        end
                        state_next = S_FINISH;
                    end
                    MODE_SEG:
                    begin
                        if (!stat.bounds_ok)
                        begin
                            res_next   = ST_OOB;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            pc_next    = PC_DD;
                            state_next = S_MICRO;
                        end
                    end
                    default:
                    begin
                        if (!stat.bounds_ok)
                        begin
                            res_next   = ST_OOB;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SPHERE;
                        end
                    end
                endcase
            end
            S_SPHERE:
            begin
                if (stat.idx_end)
                begin
                    res_next   = ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_LOADW;
                end
            end
            S_LOADW:
            begin
                cmd.load_sph = 1'b1;
                pc_next      = (stat.mode == MODE_POINT) ? PC_P : PC_T;
                state_next   = S_MICRO;
            end
            S_MICRO:
            begin
                case (uo.kind)
                    U_MUL:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = S_MWAIT;
                    end
                    U_TMP:
                    begin
                        cmd.tmp_ld = 1'b1;
                        pc_next    = pc_reg + PC_W'(1);
                    end
                    U_DD:
                    begin
                        cmd.dd_ld = 1'b1;
                        pc_next   = pc_reg + PC_W'(1);
                    end
                    U_SUMCLR:
                    begin
                        cmd.sum_clr = 1'b1;
                        pc_next     = pc_reg + PC_W'(1);
                    end
                    U_SUMSUB:
                    begin
                        cmd.sum_sub = 1'b1;
                        pc_next     = pc_reg + PC_W'(1);
                    end
                    U_SUMADD:
                    begin
                        cmd.sum_add = 1'b1;
                        pc_next     = pc_reg + PC_W'(1);
                    end
                    U_BEGIN:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_SPHERE;
                    end
                    U_BRANCH:
                    begin
                        if (stat.acc_le0)
                        begin
                            pc_next = PC_P;
                        end
                        else if (stat.acc_ge_dd)
                        begin
                            pc_next = PC_Q;
                        end
                        else
                        begin
                            pc_next = PC_X;
                        end
                    end
                    U_TEST_ACC, U_TEST_SUM:
                    begin
                        if (uo.kind == U_TEST_SUM)
                        begin
                            hit = stat.sum_ge0;
                        end
                        else if (stat.mode == MODE_POINT)
                        begin
                            hit = stat.acc_gt0;
                        end
                        else
                        begin
                            hit = stat.acc_ge0;
                        end
                        if (hit)
                        begin
                            res_next   = ST_BLOCKED;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_SPHERE;
                        end
                    end
                    default:
                    begin
                        res_next   = ST_OK;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MWAIT:
            begin
                if (stat.mul_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = S_MICRO;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/segment_sphere_collision_checker.sv
// segment_sphere_collision_checker: top level, sphere table with segment and
// point collision checks; depends on sscc_pkg, sscc_ctrl, sscc_datapath
//
// channel   direction  handshake            payload
// -------   ---------  -------------------  ---------------------------------------
// in        sink       in_valid / in_stall  mode, first_*, second_*, sphere_radius
// out       source     out_valid/out_stall  status, sphere_count
// cfg       sink       cfg_wr_en            cfg_index, cfg_data (bounds)
//
// clear, add and an out-of-bounds check step through accept, dispatch and
// result load. each multiply step runs on the single shared 34x34 multiplier
// (issue, four partial products, final add, done). a point check does a
// table read, four multiplies and a test for each held sphere; a segment
// check first computes |d|^2, then per sphere takes the endpoint test when
// the closest point is an endpoint and the cross-product test otherwise.
// a scan with no hit ends with a final index test; a check stops at the
// first blocking sphere.
// rst_n clears the sphere count and sets the bounds wide open; table
// contents are not cleared. the next beat is taken while a result waits on
// out_stall; a finished item then holds until the output register frees.
`default_nettype none

module segment_sphere_collision_checker #(
    parameter int MAX_SPHERES = sscc_pkg::DEF_MAX_SPHERES,
    parameter int DIMENSIONS  = sscc_pkg::DEF_DIMENSIONS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [sscc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sscc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input beats
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sscc_pkg::MODE_W-1:0]         mode,
    input  logic signed [sscc_pkg::COORD_W-1:0] first_x,
    input  logic signed [sscc_pkg::COORD_W-1:0] first_y,
    input  logic signed [sscc_pkg::COORD_W-1:0] first_z,
    input  logic signed [sscc_pkg::COORD_W-1:0] second_x,
    input  logic signed [sscc_pkg::COORD_W-1:0] second_y,
    input  logic signed [sscc_pkg::COORD_W-1:0] second_z,
    input  logic [sscc_pkg::RAD_W-1:0]          sphere_radius,
    // result beats
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sscc_pkg::STATUS_W-1:0]       status,
    output logic [sscc_pkg::COUNT_W-1:0]        sphere_count
);

    import sscc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: item dispatch, sphere scan and microcode sequencing
    sscc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: tables, exact wide arithmetic, bounds and result register
    sscc_datapath #(
        .MAX_SPHERES (MAX_SPHERES),
        .DIMENSIONS  (DIMENSIONS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_z       (first_z),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_z      (second_z),
        .sphere_radius (sphere_radius),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .sphere_count  (sphere_count)
    );

endmodule

`default_nettype wire

FILE: tb/sv/segment_sphere_collision_checker_test.sv
// segment_sphere_collision_checker_test: self-checking bench for the sphere table
// collision checker; depends on sscc_pkg and segment_sphere_collision_checker
`timescale 1ns / 1ps

module segment_sphere_collision_checker_test;
    import sscc_pkg::*;

    localparam int NSPH     = DEF_MAX_SPHERES;
    localparam int DIMS     = DEF_DIMENSIONS;
    localparam int ONE      = 32'h0001_0000;
    localparam int MINC     = 32'h8000_0000;
    localparam int MAXC     = 32'h7fff_ffff;
    localparam int WATCHDOG = 100000;
    localparam int N_RANDOM = 1000;

    typedef logic signed [159:0] wide_t;

    // one input beat
    typedef struct {
        logic [MODE_W-1:0] md;
        int                p[3];
        int                q[3];
        int                rad;
    } query_t;

    typedef struct {
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } verdict_t;

    // directed row: either a bound write or a beat, with an optional typed verdict
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        int                   data;
        logic [MODE_W-1:0]    md;
        int                   p0, p1, p2, q0, q1, q2;
        int                   rad;
        bit                   typed;
        logic [STATUS_W-1:0]  st;
        int                   cnt;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [MODE_W-1:0]       mode = '0;
    logic signed [COORD_W-1:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [COORD_W-1:0] second_x = '0, second_y = '0, second_z = '0;
    logic [RAD_W-1:0]        sphere_radius = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      sphere_count;

    segment_sphere_collision_checker u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .sphere_radius(sphere_radius),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .sphere_count(sphere_count)
    );

    always #5 clk = ~clk;

    // mirror of the block state: sphere table, count and bounds
    int          ctr[3][NSPH];
    int unsigned rad_tab[NSPH];
    int          held;
    int          bound[6];

    verdict_t pending[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    bit       calm = 0;
    int       sent = 0;

    // ---------------------------------------------------------------
    // collision arithmetic, exact in 160 bit two's complement
    // ---------------------------------------------------------------
    function automatic wide_t diff(int a, int b);
        return wide_t'(longint'(a) - longint'(b));
    endfunction

    function automatic bit in_box(int v[3]);
        for (int k = 0; k < DIMS; k++)
            if (v[k] < bound[2*k] || v[k] > bound[2*k+1]) return 0;
        return 1;
    endfunction

    function automatic wide_t center_dist2(int v[3], int i);
        wide_t s, d;
        s = 0;
        for (int k = 0; k < DIMS; k++) begin
            d = diff(ctr[k][i], v[k]);
            s = s + d * d;
        end
        return s;
    endfunction

    function automatic wide_t radius_sq(int i);
        wide_t r;
        r = wide_t'({128'b0, rad_tab[i]});
        return r * r;
    endfunction

    // clamp the projection to the endpoints, else compare |w x d|^2 with r^2 |d|^2
    function automatic bit segment_blocked(int a[3], int b[3], int i);
        wide_t w[3], d[3];
        wide_t dd, t, cr, c, rr;
        dd = 0;
        t = 0;
        cr = 0;
        rr = radius_sq(i);
        for (int k = 0; k < DIMS; k++) begin
            w[k] = diff(ctr[k][i], a[k]);
            d[k] = diff(b[k], a[k]);
            dd = dd + d[k] * d[k];
            t = t + w[k] * d[k];
        end
        if (t <= 0) return center_dist2(a, i) <= rr;
        if (dd <= t) return center_dist2(b, i) <= rr;
        for (int m = 0; m < DIMS; m++)
            for (int n = m + 1; n < DIMS; n++) begin
                c = w[m] * d[n] - w[n] * d[m];
                cr = cr + c * c;
            end
        return cr <= rr * dd;
    endfunction

    function automatic verdict_t collision_verdict(query_t it);
        verdict_t v;
        v.st = ST_OK;
        case (it.md)
            MODE_CLEAR: held = 0;
            MODE_ADD: begin
                if (held >= NSPH) v.st = ST_FULL;
                else begin
                    for (int k = 0; k < 3; k++) ctr[k][held] = it.p[k];
                    rad_tab[held] = it.rad & 32'h7fff_ffff;
                    held++;
                end
            end
            MODE_SEG: begin
                if (!in_box(it.p) || !in_box(it.q)) v.st = ST_OOB;
                else
                    for (int i = 0; i < held; i++)
                        if (segment_blocked(it.p, it.q, i)) begin
                            v.st = ST_BLOCKED;
                            break;
                        end
            end
            default: begin
                if (!in_box(it.p)) v.st = ST_OOB;
                else
                    for (int i = 0; i < held; i++)
                        if (center_dist2(it.p, i) < radius_sq(i)) begin
                            v.st = ST_BLOCKED;
                            break;
                        end
            end
        endcase
        v.cnt = held[COUNT_W-1:0];
        return v;
    endfunction

    // ---------------------------------------------------------------
    // result side: stall pattern, checking and the watchdog
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: status %0d count %0d",
                       status, sphere_count);
                errors++;
            end else begin
                if (status !== pending[0].st) begin
                    $error("status: expected %0d, got %0d", pending[0].st, status);
                    errors++;
                end
                if (sphere_count !== pending[0].cnt) begin
                    $error("sphere_count: expected %0d, got %0d",
                           pending[0].cnt, sphere_count);
                    errors++;
                end
                void'(pending.pop_front());
            end
        end
        // stall runs of random length, none started while calm
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
        // nothing moved on either channel
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------
    // drive one beat, hold until taken, then record what it should produce
    task automatic send_query(query_t it, bit typed, verdict_t typed_v);
        verdict_t v;
        in_valid      <= 1'b1;
        mode          <= it.md;
        first_x       <= it.p[0];
        first_y       <= it.p[1];
        first_z       <= it.p[2];
        second_x      <= it.q[0];
        second_y      <= it.q[1];
        second_z      <= it.q[2];
        sphere_radius <= it.rad[RAD_W-1:0];
        do @(posedge clk); while (in_stall);
        v = collision_verdict(it);
        pending.push_back(typed ? typed_v : v);
        sent++;
        begin
            int g;
            g = pick_gap();
            if (g > 0) begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    // sender holds off until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, int v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        bound[idx] = v;
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return int'($urandom_range(0, 1 << 19)) - (1 << 18);
        if (r < 92) return $urandom;
        case ($urandom_range(0, 3))
            0: return MINC;
            1: return MAXC;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int rand_radius();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 1 << 17);
        return $urandom & 32'h7fff_ffff;
    endfunction

    // random bound pair for one axis: open, a box, inverted or pinned to an extreme
    task automatic rand_axis(logic [CFG_IDX_W-1:0] lo_idx, logic [CFG_IDX_W-1:0] hi_idx);
        int lo, hi;
        case ($urandom_range(0, 5))
            0, 1: begin lo = MINC; hi = MAXC; end
            2: begin lo = -int'($urandom_range(1, 1 << 18)); hi = $urandom_range(0, 1 << 18); end
            3: begin lo = $urandom_range(1, 1 << 16); hi = -int'($urandom_range(0, 1 << 16)); end
            4: begin lo = MAXC; hi = MAXC; end
            default: begin lo = MINC; hi = MINC; end
        endcase
        write_bound(lo_idx, lo);
        write_bound(hi_idx, hi);
    endtask

    // mostly clear first, fill a few spheres, then a run of checks at random coordinates
    task automatic random_scene();
        query_t   it;
        verdict_t none;
        int       nadd, nchk;
        none = '{ST_OK, '0};
        calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0) begin
            it = '{MODE_CLEAR, '{rand_coord(), rand_coord(), rand_coord()},
                   '{rand_coord(), rand_coord(), rand_coord()}, rand_radius()};
            send_query(it, 0, none);
        end
        nadd = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 6);
        for (int i = 0; i < nadd; i++) begin
            it = '{MODE_ADD, '{rand_coord(), rand_coord(), rand_coord()},
                   '{rand_coord(), rand_coord(), rand_coord()}, rand_radius()};
            send_query(it, 0, none);
        end
        nchk = (nadd > 20) ? 3 : $urandom_range(3, 12);
        for (int i = 0; i < nchk; i++) begin
            it.md = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom) :
                    ($urandom_range(0, 1) ? MODE_SEG : MODE_POINT);
            it.p = '{rand_coord(), rand_coord(), rand_coord()};
            it.q = '{rand_coord(), rand_coord(), rand_coord()};
            if ($urandom_range(0, 9) == 0) it.q = it.p;   // zero-length segment
            it.rad = $urandom;
            send_query(it, 0, none);
        end
        calm = 0;
    endtask

    // directed beats: typed verdicts where they are plain to see
    row_t directed[] = '{
        '{0, CFG_LOW_X, 0, MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_SEG, MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 1, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_ADD, 0, 0, 0, 0, 0, 0, ONE, 1, ST_OK, 1},
        '{0, CFG_LOW_X, 0, MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 1, ST_BLOCKED, 1},
        // point exactly on the surface is free
        '{0, CFG_LOW_X, 0, MODE_POINT, ONE, 0, 0, 0, 0, 0, 0, 1, ST_OK, 1},
        // segment grazing the surface is blocked
        '{0, CFG_LOW_X, 0, MODE_SEG, -2*ONE, ONE, 0, 2*ONE, ONE, 0, 0, 1, ST_BLOCKED, 1},
        // zero-length segments
        '{0, CFG_LOW_X, 0, MODE_SEG, ONE, 0, 0, ONE, 0, 0, 0, 1, ST_BLOCKED, 1},
        '{0, CFG_LOW_X, 0, MODE_SEG, 2*ONE, 0, 0, 2*ONE, 0, 0, 0, 1, ST_OK, 1},
        // projection clamped to the near endpoint
        '{0, CFG_LOW_X, 0, MODE_SEG, 2*ONE, 0, 0, 4*ONE, 0, 0, 0, 1, ST_OK, 1},
        '{0, CFG_LOW_X, 0, MODE_ADD, MAXC, MAXC, MAXC, 0, 0, 0, MAXC, 1, ST_OK, 2},
        '{0, CFG_LOW_X, 0, MODE_ADD, MINC, MINC, MINC, 0, 0, 0, 0, 1, ST_OK, 3},
        '{0, CFG_LOW_X, 0, MODE_POINT, MINC, MINC, MINC, 0, 0, 0, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_SEG, MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_SEG, MAXC, MINC, MAXC, MINC, MAXC, MINC, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_POINT, -1, -1, -1, 0, 0, 0, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0},
        '{1, CFG_LOW_X, -ONE, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{1, CFG_HIGH_X, ONE, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_POINT, 2*ONE, 0, 0, 0, 0, 0, 0, 1, ST_OOB, 0},
        '{0, CFG_LOW_X, 0, MODE_SEG, 0, 0, 0, -2*ONE, 0, 0, 0, 1, ST_OOB, 0},
        // inverted y bounds reject everything
        '{1, CFG_LOW_Y, 5, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{1, CFG_HIGH_Y, -5, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 1, ST_OOB, 0},
        '{1, CFG_LOW_Y, MINC, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{1, CFG_HIGH_Y, MAXC, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{1, CFG_LOW_X, MINC, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{1, CFG_HIGH_X, MAXC, MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK, 0},
        '{0, CFG_LOW_X, 0, MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 0}
    };

    initial begin
        query_t   it;
        verdict_t tv;
        held = 0;
        bound = '{MINC, MAXC, MINC, MAXC, MINC, MAXC};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n]) begin
            if (directed[n].is_cfg) begin
                drain();
                write_bound(directed[n].idx, directed[n].data);
            end else begin
                it = '{directed[n].md, '{directed[n].p0, directed[n].p1, directed[n].p2},
                       '{directed[n].q0, directed[n].q1, directed[n].q2}, directed[n].rad};
                tv = '{directed[n].st, COUNT_W'(directed[n].cnt)};
                send_query(it, directed[n].typed, tv);
            end
        end

        // fill the table to the brim, then one add too many
        for (int i = 0; i < NSPH; i++) begin
            it = '{MODE_ADD, '{i * 4 * ONE, 0, 0}, '{0, 0, 0}, ONE};
            send_query(it, 0, tv);
        end
        it = '{MODE_ADD, '{0, 0, 0}, '{0, 0, 0}, ONE};
        send_query(it, 1, '{ST_FULL, COUNT_W'(NSPH)});
        it = '{MODE_POINT, '{(NSPH - 1) * 4 * ONE, 0, 0}, '{0, 0, 0}, 0};
        send_query(it, 1, '{ST_BLOCKED, COUNT_W'(NSPH)});

        // random part, with bound changes between phases
        sent = 0;
        while (sent < N_RANDOM) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                rand_axis(CFG_LOW_X, CFG_HIGH_X);
                rand_axis(CFG_LOW_Y, CFG_HIGH_Y);
                rand_axis(CFG_LOW_Z, CFG_HIGH_Z);
            end
            random_scene();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/sscc_pkg.sv
hw/rtl/sscc_ram.sv
hw/rtl/sscc_mul.sv
hw/rtl/sscc_datapath.sv
hw/rtl/sscc_ctrl.sv
hw/rtl/segment_sphere_collision_checker.sv
tb/sv/segment_sphere_collision_checker_test.sv
